// ===== rtl/core/um32_register_execute_unit_core_defines.svh =====
// ----------------------------------------------------------------------------
// UM32 execute unit assertion macros
// Concurrent assertion wrappers clocked by clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef UM32_REGISTER_EXECUTE_UNIT_CORE_DEFINES_SVH
`define UM32_REGISTER_EXECUTE_UNIT_CORE_DEFINES_SVH

`ifndef SYNTH
`define UM32_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define UM32_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UM32_ASSERT(label, prop, msg)
`define UM32_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/core/um32_pkg.sv =====
// ----------------------------------------------------------------------------
// UM32 execute unit package
// Shared widths, instruction field positions, result codes and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package um32_pkg;

    localparam int unsigned XLEN      = 32;
    localparam int unsigned NREG      = 8;
    localparam int unsigned RIDX_W    = 3;
    localparam int unsigned OPC_W     = 4;
    localparam int unsigned IMM_W     = 25;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned CNT_W     = 5;

    // Instruction field positions.
    localparam int unsigned OPC_LSB   = 28;
    localparam int unsigned LI_R_LSB  = 25;
    localparam int unsigned RA_LSB    = 6;
    localparam int unsigned RB_LSB    = 3;
    localparam int unsigned RC_LSB    = 0;

    localparam logic [OPC_W-1:0] OPC_CMOV     = 4'd0;
    localparam logic [OPC_W-1:0] OPC_SEGLOAD  = 4'd1;
    localparam logic [OPC_W-1:0] OPC_SEGSTORE = 4'd2;
    localparam logic [OPC_W-1:0] OPC_ADD      = 4'd3;
    localparam logic [OPC_W-1:0] OPC_MUL      = 4'd4;
    localparam logic [OPC_W-1:0] OPC_DIV      = 4'd5;
    localparam logic [OPC_W-1:0] OPC_NAND     = 4'd6;
    localparam logic [OPC_W-1:0] OPC_HALT     = 4'd7;
    localparam logic [OPC_W-1:0] OPC_MAP      = 4'd8;
    localparam logic [OPC_W-1:0] OPC_UNMAP    = 4'd9;
    localparam logic [OPC_W-1:0] OPC_OUTPUT   = 4'd10;
    localparam logic [OPC_W-1:0] OPC_INPUT    = 4'd11;
    localparam logic [OPC_W-1:0] OPC_LOADPROG = 4'd12;
    localparam logic [OPC_W-1:0] OPC_LOADIMM  = 4'd13;

    typedef enum logic [2:0] {
        KIND_DONE  = 3'd0,
        KIND_CHAR  = 3'd1,
        KIND_MEM   = 3'd2,
        KIND_HALT  = 3'd3,
        KIND_DIVZ  = 3'd4,
        KIND_BADOP = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        MOP_SEGLOAD  = 3'd0,
        MOP_SEGSTORE = 3'd1,
        MOP_MAP      = 3'd2,
        MOP_UNMAP    = 3'd3,
        MOP_LOADPROG = 3'd4
    } mem_op_t;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_MUL = 2'd1,
        ALU_DIV = 2'd2
    } alu_func_t;

    typedef struct packed {
        logic      start;
        alu_func_t func;
    } alu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_rsp_t;

    typedef struct packed {
        logic              en;
        logic [RIDX_W-1:0] addr;
    } rf_wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/um32_register_execute_unit_core.sv =====
// ----------------------------------------------------------------------------
// UM32 register execute unit
// Sequencer, operand fetch, result register and serial arithmetic unit.
// ----------------------------------------------------------------------------
// Usage: one word enters on in_valid/in_stall: either an instruction to
// execute or a writeback of a memory unit result into a register. Every
// accepted word yields exactly one result word on out_valid/out_stall.
// Operands are read from the register file one per cycle (A, B, C) before a
// register instruction executes. Add, multiply and divide by a nonzero
// divisor run in the serial arithmetic unit, which takes one operand bit per
// cycle. The unit works on one word at a time; in_stall is low only when
// it is ready for the next word.
// The finished result sits in an output register, so the next word may be
// accepted while that result is still stalled. A result that finds the output
// register still full waits in the sequencer until the receiver takes it.
// Reset empties the output register, returns the sequencer to idle and makes
// all eight registers read as zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module um32_register_execute_unit_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic [31:0] instruction,
    input  wire logic [7:0]  in_char,
    input  wire logic        in_eof,
    input  wire logic [2:0]  wb_register,
    input  wire logic [31:0] wb_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic [2:0]       mem_op,
    output logic [31:0]      operand_a,
    output logic [31:0]      operand_b,
    output logic [31:0]      operand_c,
    output logic [2:0]       target_register,
    output logic [7:0]       out_char
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_RD_A   = 8'b0000_0010,
        ST_RD_B   = 8'b0000_0100,
        ST_RD_C   = 8'b0000_1000,
        ST_OPND   = 8'b0001_0000,
        ST_EXEC   = 8'b0010_0000,
        ST_ARITH  = 8'b0100_0000,
        ST_WRITE  = 8'b1000_0000
    } state_t;

    // Finishing has no state of its own: a pending flag marks a result that waits in idle.
    state_t                             state_reg;
    state_t                             state_next;
    logic                               pend_reg;

    logic                               op_item_reg;
    logic [um32_pkg::XLEN-1:0]          instr_reg;
    logic [um32_pkg::CHAR_W-1:0]        char_reg;
    logic                               eof_reg;
    logic [um32_pkg::RIDX_W-1:0]        wbr_reg;
    logic [um32_pkg::XLEN-1:0]          wbv_reg;
    logic [um32_pkg::XLEN-1:0]          va_reg;
    logic [um32_pkg::XLEN-1:0]          vb_reg;
    logic [um32_pkg::XLEN-1:0]          vc_reg;

    um32_pkg::kind_t                    res_kind_reg;
    um32_pkg::mem_op_t                  res_mop_reg;
    logic [um32_pkg::XLEN-1:0]          res_a_reg;
    logic [um32_pkg::XLEN-1:0]          res_b_reg;
    logic [um32_pkg::XLEN-1:0]          res_c_reg;
    logic [um32_pkg::RIDX_W-1:0]        res_tgt_reg;
    logic [um32_pkg::CHAR_W-1:0]        res_char_reg;

    logic                               out_valid_reg;
    logic [2:0]                         kind_reg;
    logic [2:0]                         mem_op_reg;
    logic [31:0]                        operand_a_reg;
    logic [31:0]                        operand_b_reg;
    logic [31:0]                        operand_c_reg;
    logic [2:0]                         target_register_reg;
    logic [7:0]                         out_char_reg;

    logic [um32_pkg::OPC_W-1:0]         opc;
    logic [um32_pkg::RIDX_W-1:0]        ra;
    logic [um32_pkg::RIDX_W-1:0]        rb;
    logic [um32_pkg::RIDX_W-1:0]        rc;
    logic [um32_pkg::RIDX_W-1:0]        li_reg_idx;
    logic [um32_pkg::IMM_W-1:0]         imm;

    logic                               in_take;
    logic                               out_free;
    logic                               res_load;

    logic [um32_pkg::RIDX_W-1:0]        rf_rd_addr;
    logic [um32_pkg::XLEN-1:0]          rf_rd_data;
    um32_pkg::rf_wr_t                   rf_wr;
    logic [um32_pkg::XLEN-1:0]          rf_wr_data;

    um32_pkg::alu_req_t                 alu_req;
    um32_pkg::alu_rsp_t                 alu_rsp;
    logic [um32_pkg::XLEN-1:0]          alu_result;

    assign opc        = instr_reg[um32_pkg::OPC_LSB +: um32_pkg::OPC_W];
    assign ra         = instr_reg[um32_pkg::RA_LSB +: um32_pkg::RIDX_W];
    assign rb         = instr_reg[um32_pkg::RB_LSB +: um32_pkg::RIDX_W];
    assign rc         = instr_reg[um32_pkg::RC_LSB +: um32_pkg::RIDX_W];
    assign li_reg_idx = instr_reg[um32_pkg::LI_R_LSB +: um32_pkg::RIDX_W];
    assign imm        = instr_reg[um32_pkg::IMM_W-1:0];

    assign out_free = !out_valid_reg || !out_stall;
    // A pending result blocks the next word until it moves to the output register.
    assign in_stall = (state_reg != ST_IDLE) || pend_reg;
    assign in_take  = in_valid && !in_stall;
    assign res_load = pend_reg && out_free;

    // Sequencer: operand reads, execute, serial arithmetic, writeback.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = operation ? ST_WRITE : ST_RD_A;
                end
            end
            ST_RD_A:  state_next = ST_RD_B;
            ST_RD_B:  state_next = ST_RD_C;
            ST_RD_C:  state_next = ST_OPND;
            ST_OPND:  state_next = ST_EXEC;
            ST_EXEC:  state_next = alu_req.start ? ST_ARITH : ST_IDLE;
            ST_ARITH:
            begin
                if (alu_rsp.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WRITE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_EXEC && !alu_req.start) ||
                (state_reg == ST_ARITH && alu_rsp.done) ||
                (state_reg == ST_WRITE))
            begin
                pend_reg <= 1'b1;
            end
            else if (res_load)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_item_reg <= operation;
            instr_reg   <= instruction;
            char_reg    <= in_char;
            eof_reg     <= in_eof;
            wbr_reg     <= wb_register;
            wbv_reg     <= wb_value;
        end
        if (state_reg == ST_RD_B)
        begin
            va_reg <= rf_rd_data;
        end
        if (state_reg == ST_RD_C)
        begin
            vb_reg <= rf_rd_data;
        end
        if (state_reg == ST_OPND)
        begin
            vc_reg <= rf_rd_data;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_RD_A: rf_rd_addr = ra;
            ST_RD_B: rf_rd_addr = rb;
            ST_RD_C: rf_rd_addr = rc;
            default: rf_rd_addr = ra;
        endcase
    end

    // Register file write port.
    always_comb
    begin
        rf_wr.en   = 1'b0;
        rf_wr.addr = ra;
        rf_wr_data = vb_reg;
        if (state_reg == ST_EXEC)
        begin
            unique case (opc)
                um32_pkg::OPC_CMOV:
                begin
                    rf_wr.en = (vc_reg != '0);
                end
                um32_pkg::OPC_NAND:
                begin
                    rf_wr.en   = 1'b1;
                    rf_wr_data = ~(vb_reg & vc_reg);
                end
                um32_pkg::OPC_INPUT:
                begin
                    rf_wr.en   = 1'b1;
                    rf_wr.addr = rc;
                    rf_wr_data = eof_reg ? '1 : {{(um32_pkg::XLEN-um32_pkg::CHAR_W){1'b0}},
                                                 char_reg};
                end
                um32_pkg::OPC_LOADIMM:
                begin
                    rf_wr.en   = 1'b1;
                    rf_wr.addr = li_reg_idx;
                    rf_wr_data = {{(um32_pkg::XLEN-um32_pkg::IMM_W){1'b0}}, imm};
                end
                default:
                begin
                    rf_wr.en = 1'b0;
                end
            endcase
        end
        else if (state_reg == ST_ARITH)
        begin
            rf_wr.en   = alu_rsp.done;
            rf_wr_data = alu_result;
        end
        else if (state_reg == ST_WRITE && op_item_reg)
        begin
            rf_wr.en   = 1'b1;
            rf_wr.addr = wbr_reg;
            rf_wr_data = wbv_reg;
        end
    end

    always_comb
    begin
        alu_req.start = 1'b0;
        alu_req.func  = um32_pkg::ALU_ADD;
        if (state_reg == ST_EXEC)
        begin
            unique case (opc)
                um32_pkg::OPC_ADD:
                begin
                    alu_req.start = 1'b1;
                end
                um32_pkg::OPC_MUL:
                begin
                    alu_req.start = 1'b1;
                    alu_req.func  = um32_pkg::ALU_MUL;
                end
                um32_pkg::OPC_DIV:
                begin
                    alu_req.start = (vc_reg != '0);
                    alu_req.func  = um32_pkg::ALU_DIV;
                end
                default:
                begin
                    alu_req.start = 1'b0;
                end
            endcase
        end
    end

    // Result fields; anything not named below stays zero.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC || state_reg == ST_WRITE)
        begin
            res_kind_reg <= um32_pkg::KIND_DONE;
            res_mop_reg  <= um32_pkg::MOP_SEGLOAD;
            res_a_reg    <= '0;
            res_b_reg    <= '0;
            res_c_reg    <= '0;
            res_tgt_reg  <= '0;
            res_char_reg <= '0;
            if (state_reg == ST_EXEC)
            begin
                unique case (opc) inside
                    um32_pkg::OPC_SEGLOAD,
                    um32_pkg::OPC_SEGSTORE,
                    um32_pkg::OPC_MAP,
                    um32_pkg::OPC_UNMAP,
                    um32_pkg::OPC_LOADPROG:
                    begin
                        res_kind_reg <= um32_pkg::KIND_MEM;
                        res_a_reg    <= va_reg;
                        res_b_reg    <= vb_reg;
                        res_c_reg    <= vc_reg;
                        if (opc == um32_pkg::OPC_SEGLOAD)
                        begin
                            res_tgt_reg <= ra;
                        end
                        else if (opc == um32_pkg::OPC_MAP)
                        begin
                            res_tgt_reg <= rb;
                        end
                        unique case (opc)
                            um32_pkg::OPC_SEGSTORE: res_mop_reg <= um32_pkg::MOP_SEGSTORE;
                            um32_pkg::OPC_MAP:      res_mop_reg <= um32_pkg::MOP_MAP;
                            um32_pkg::OPC_UNMAP:    res_mop_reg <= um32_pkg::MOP_UNMAP;
                            um32_pkg::OPC_LOADPROG: res_mop_reg <= um32_pkg::MOP_LOADPROG;
                            default:                res_mop_reg <= um32_pkg::MOP_SEGLOAD;
                        endcase
                    end
                    um32_pkg::OPC_DIV:
                    begin
                        if (vc_reg == '0)
                        begin
                            res_kind_reg <= um32_pkg::KIND_DIVZ;
                        end
                    end
                    um32_pkg::OPC_HALT:
                    begin
                        res_kind_reg <= um32_pkg::KIND_HALT;
                    end
                    um32_pkg::OPC_OUTPUT:
                    begin
                        res_kind_reg <= um32_pkg::KIND_CHAR;
                        res_char_reg <= vc_reg[um32_pkg::CHAR_W-1:0];
                    end
                    um32_pkg::OPC_CMOV,
                    um32_pkg::OPC_ADD,
                    um32_pkg::OPC_MUL,
                    um32_pkg::OPC_NAND,
                    um32_pkg::OPC_INPUT,
                    um32_pkg::OPC_LOADIMM:
                    begin
                        res_kind_reg <= um32_pkg::KIND_DONE;
                    end
                    default:
                    begin
                        res_kind_reg <= um32_pkg::KIND_BADOP;
                    end
                endcase
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            kind_reg            <= res_kind_reg;
            mem_op_reg          <= res_mop_reg;
            operand_a_reg       <= res_a_reg;
            operand_b_reg       <= res_b_reg;
            operand_c_reg       <= res_c_reg;
            target_register_reg <= res_tgt_reg;
            out_char_reg        <= res_char_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign mem_op          = mem_op_reg;
    assign operand_a       = operand_a_reg;
    assign operand_b       = operand_b_reg;
    assign operand_c       = operand_c_reg;
    assign target_register = target_register_reg;
    assign out_char        = out_char_reg;

    um32_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rf_rd_addr),
        .rd_data (rf_rd_data),
        .wr      (rf_wr),
        .wr_data (rf_wr_data)
    );

    um32_serial_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .b      (vb_reg),
        .c      (vc_reg),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

endmodule

`default_nettype wire

// ===== rtl/core/um32_regfile.sv =====
// ----------------------------------------------------------------------------
// UM32 register file
// Eight 32-bit registers, one write and one registered read port per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module um32_regfile (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [um32_pkg::RIDX_W-1:0]    rd_addr,
    output logic      [um32_pkg::XLEN-1:0]      rd_data,
    input  wire um32_pkg::rf_wr_t               wr,
    input  wire logic [um32_pkg::XLEN-1:0]      wr_data
);

    logic [um32_pkg::XLEN-1:0] mem [um32_pkg::NREG];
    logic [um32_pkg::NREG-1:0] valid_reg;
    logic [um32_pkg::XLEN-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr_data;
        end
    end

    // A register never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/um32_serial_alu.sv =====
// ----------------------------------------------------------------------------
// UM32 serial arithmetic unit
// Add, multiply and divide modulo 2^32, one operand bit per cycle over 32 steps.
// ----------------------------------------------------------------------------
`default_nettype none

`include "um32_register_execute_unit_core_defines.svh"

module um32_serial_alu (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire um32_pkg::alu_req_t        req,
    input  wire logic [um32_pkg::XLEN-1:0] b,
    input  wire logic [um32_pkg::XLEN-1:0] c,
    output um32_pkg::alu_rsp_t             rsp,
    output logic      [um32_pkg::XLEN-1:0] result
);

    localparam logic [um32_pkg::CNT_W-1:0] CNT_LAST = um32_pkg::CNT_W'(um32_pkg::XLEN - 1);
    localparam logic [um32_pkg::CNT_W-1:0] CNT_ONE  = um32_pkg::CNT_W'(1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [um32_pkg::CNT_W-1:0]    cnt_reg;
    um32_pkg::alu_func_t           func_reg;
    logic [um32_pkg::XLEN-1:0]     b_reg;
    logic [um32_pkg::XLEN-1:0]     c_reg;
    logic [um32_pkg::XLEN-1:0]     acc_reg;
    logic [um32_pkg::XLEN-1:0]     rem_reg;
    logic                          carry_reg;

    logic                          sum_bit;
    logic                          carry_next;
    logic [um32_pkg::XLEN-1:0]     acc_next;
    logic [um32_pkg::XLEN:0]       trial;
    logic [um32_pkg::XLEN:0]       diff;
    logic                          q_bit;

    assign sum_bit    = b_reg[0] ^ c_reg[0] ^ carry_reg;
    assign carry_next = (b_reg[0] & c_reg[0]) | (carry_reg & (b_reg[0] ^ c_reg[0]));
    assign acc_next   = acc_reg + (b_reg[0] ? c_reg : '0);

    // Restoring division: the dividend shifts out of b_reg as quotient bits shift in.
    assign trial = {rem_reg, b_reg[um32_pkg::XLEN-1]};
    assign diff  = trial - {1'b0, c_reg};
    assign q_bit = (trial >= {1'b0, c_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_ONE;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            func_reg  <= req.func;
            b_reg     <= b;
            c_reg     <= c;
            acc_reg   <= '0;
            rem_reg   <= '0;
            carry_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            case (func_reg)
                um32_pkg::ALU_ADD:
                begin
                    acc_reg   <= {sum_bit, acc_reg[um32_pkg::XLEN-1:1]};
                    carry_reg <= carry_next;
                    b_reg     <= b_reg >> 1;
                    c_reg     <= c_reg >> 1;
                end
                um32_pkg::ALU_MUL:
                begin
                    acc_reg <= acc_next;
                    b_reg   <= b_reg >> 1;
                    c_reg   <= c_reg << 1;
                end
                um32_pkg::ALU_DIV:
                begin
                    rem_reg <= q_bit ? diff[um32_pkg::XLEN-1:0] : trial[um32_pkg::XLEN-1:0];
                    b_reg   <= {b_reg[um32_pkg::XLEN-2:0], q_bit};
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign result   = (func_reg == um32_pkg::ALU_DIV) ? b_reg : acc_reg;

    // The step counter only reaches its last value while a run is in progress.
    `UM32_ASSERT(a_done_follows_busy, done_reg |-> $past(busy_reg), "ALU done without a run")
    `UM32_ASSERT(a_no_start_when_busy, req.start |-> !busy_reg, "ALU started while busy")
    `UM32_ASSERT_NEXT(a_last_step, cnt_reg == CNT_LAST, done_reg && !busy_reg, "ALU overran")

endmodule

`default_nettype wire
